@@ rtl/assert_macros.svh @@
// Assertion helpers for the decoder modules.
// Each module that asserts has ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define B64_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define B64_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/b64_pkg.sv @@
package b64_pkg;

   // Alphabet characters
   localparam logic [7:0] CHAR_UPPER_A    = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'd90;
   localparam logic [7:0] CHAR_LOWER_A    = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'd122;
   localparam logic [7:0] CHAR_DIGIT_0    = 8'd48;
   localparam logic [7:0] CHAR_DIGIT_9    = 8'd57;
   localparam logic [7:0] CHAR_PLUS       = 8'd43;
   localparam logic [7:0] CHAR_SLASH      = 8'd47;
   localparam logic [7:0] CHAR_DASH       = 8'd45;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'd95;
   localparam logic [7:0] CHAR_PAD        = 8'd61;

   // Offsets that turn a character into its sextet (modulo 256)
   localparam logic [7:0] OFFSET_LOWER = 8'd71;   // 'a' - 26
   localparam logic [7:0] OFFSET_DIGIT = 8'd4;    // 52 - '0'

   localparam logic [5:0] SEXTET_62 = 6'd62;
   localparam logic [5:0] SEXTET_63 = 6'd63;

   // Alphabet modes
   localparam logic MODE_STANDARD = 1'b0;
   localparam logic MODE_URL      = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR   = 2'd1;
   localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

   // Quantum positions
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

   typedef struct packed {
      logic [5:0] sextet;
      logic       is_pad;
      logic       is_bad;
   } sextet_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic [1:0] status;
      logic       message_end;
   } result_type;

endpackage

@@ rtl/b64_char_map.sv @@
module b64_char_map (
   input  logic                [7:0] text_char,
   input  logic                      alphabet_mode,
   output b64_pkg::sextet_type       map
);

   logic [7:0] upper_ofs;
   logic [7:0] lower_ofs;
   logic [7:0] digit_ofs;

   assign upper_ofs = text_char - b64_pkg::CHAR_UPPER_A;
   assign lower_ofs = text_char - b64_pkg::OFFSET_LOWER;
   assign digit_ofs = text_char + b64_pkg::OFFSET_DIGIT;

   // Translate one character into a sextet, a pad mark or a reject
   always_comb begin
      map.sextet = '0;
      map.is_pad = 1'b0;
      map.is_bad = 1'b0;
      priority if (text_char >= b64_pkg::CHAR_UPPER_A && text_char <= b64_pkg::CHAR_UPPER_Z) begin
         map.sextet = upper_ofs[5:0];
      end else if (text_char >= b64_pkg::CHAR_LOWER_A &&
                   text_char <= b64_pkg::CHAR_LOWER_Z) begin
         map.sextet = lower_ofs[5:0];
      end else if (text_char >= b64_pkg::CHAR_DIGIT_0 &&
                   text_char <= b64_pkg::CHAR_DIGIT_9) begin
         map.sextet = digit_ofs[5:0];
      end else if (alphabet_mode == b64_pkg::MODE_URL) begin
         priority if (text_char == b64_pkg::CHAR_DASH) begin
            map.sextet = b64_pkg::SEXTET_62;
         end else if (text_char == b64_pkg::CHAR_UNDERSCORE) begin
            map.sextet = b64_pkg::SEXTET_63;
         end else begin
            map.is_bad = 1'b1;
         end
      end else begin
         priority if (text_char == b64_pkg::CHAR_PLUS) begin
            map.sextet = b64_pkg::SEXTET_62;
         end else if (text_char == b64_pkg::CHAR_SLASH) begin
            map.sextet = b64_pkg::SEXTET_63;
         end else if (text_char == b64_pkg::CHAR_PAD) begin
            map.is_pad = 1'b1;
         end else begin
            map.is_bad = 1'b1;
         end
      end
   end

endmodule

@@ rtl/b64_decode_core.sv @@
`include "assert_macros.svh"

module b64_decode_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      alphabet_mode,
   input  logic                [7:0] text_char,
   input  logic                      last_char,
   output b64_pkg::result_type       result
);

   logic [1:0] pos_ff;
   logic [1:0] pos_in;
   logic [5:0] prev_ff;
   logic [5:0] prev_in;
   logic       pad_stop_ff;
   logic       pad_stop_in;
   logic       err_ff;
   logic       err_in;

   b64_pkg::sextet_type map;

   logic       url;
   logic       active;
   logic       bad;
   logic       pad;
   logic [5:0] sextet;
   logic       emit;
   logic       err_now;
   logic       len_bad;

   b64_char_map u_char_map (
      .text_char     (text_char),
      .alphabet_mode (alphabet_mode),
      .map           (map)
   );

   assign url    = (alphabet_mode == b64_pkg::MODE_URL);
   assign active = !err_ff && !pad_stop_ff;

   // Classify the character for its place in the quantum
   always_comb begin
      bad    = 1'b0;
      pad    = 1'b0;
      sextet = map.sextet;
      priority if (pos_ff == b64_pkg::POS_FIRST || pos_ff == b64_pkg::POS_SECOND) begin
         bad = map.is_bad || map.is_pad;
      end else if (!url) begin
         pad = map.is_pad;
         bad = map.is_bad;
      end else if (map.is_bad) begin
         // URL tail: a reject decodes as zero unless it is the last character
         // and sits in the third slot
         if (pos_ff == b64_pkg::POS_THIRD && last_char) begin
            bad = 1'b1;
         end else begin
            sextet = '0;
         end
      end else begin
         // URL tail character from the alphabet: take it as mapped
         sextet = map.sextet;
      end
   end

   assign emit    = active && !bad && !pad && (pos_ff != b64_pkg::POS_FIRST);
   assign err_now = err_ff || (active && bad);
   assign len_bad = url ? (pos_ff == b64_pkg::POS_FIRST) : (pos_ff != b64_pkg::POS_FOURTH);

   // Assemble the result for this character
   always_comb begin
      result.data_byte   = '0;
      result.byte_valid  = emit;
      result.message_end = last_char;
      if (emit) begin
         unique case (pos_ff)
            b64_pkg::POS_SECOND: result.data_byte = {prev_ff, sextet[5:4]};
            b64_pkg::POS_THIRD:  result.data_byte = {prev_ff[3:0], sextet[5:2]};
            b64_pkg::POS_FOURTH: result.data_byte = {prev_ff[1:0], sextet};
            default:             result.data_byte = '0;
         endcase
      end
      priority if (err_now) begin
         result.status = b64_pkg::STATUS_BAD_CHAR;
      end else if (last_char && len_bad) begin
         result.status = b64_pkg::STATUS_BAD_LENGTH;
      end else begin
         result.status = b64_pkg::STATUS_OK;
      end
   end

   // Advance the quantum state; clear it at the end of a message
   always_comb begin
      pos_in      = pos_ff;
      prev_in     = prev_ff;
      pad_stop_in = pad_stop_ff;
      err_in      = err_ff;
      if (advance) begin
         if (last_char) begin
            pos_in      = b64_pkg::POS_FIRST;
            prev_in     = '0;
            pad_stop_in = 1'b0;
            err_in      = 1'b0;
         end else begin
            pos_in = pos_ff + 2'd1;
            err_in = err_now;
            if (active && pad) begin
               pad_stop_in = 1'b1;
            end
            if (active && !bad && !pad) begin
               prev_in = sextet;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= b64_pkg::POS_FIRST;
         prev_ff     <= '0;
         pad_stop_ff <= 1'b0;
         err_ff      <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         prev_ff     <= prev_in;
         pad_stop_ff <= pad_stop_in;
         err_ff      <= err_in;
      end
   end

   `B64_ASSERT_NEXT(a_end_clears, advance && last_char,
      pos_ff == b64_pkg::POS_FIRST && !err_ff && !pad_stop_ff,
      "message end did not clear the quantum state")
   `B64_ASSERT_SAME(a_pad_err_excl, pad_stop_ff, !err_ff,
      "padding stop and error latched together")
   `B64_ASSERT_SAME(a_no_byte_first, result.byte_valid, pos_ff != b64_pkg::POS_FIRST,
      "byte completed at the first position of a quantum")

endmodule

@@ rtl/base64_stream_decoder.sv @@
// Base64 text decoder, one character per transaction.
// req_* carries characters (tlast marks the last character of a message).
// rsp_* carries one result per character: the decoded byte with its valid
// flag and a status code; rsp_tlast repeats the message end mark.
// csr_* writes the alphabet mode (0 standard with padding, 1 URL-safe);
// write it only while no character is in flight.
// An accepted character is held in the input register, then decoded
// into the output register, which presents its result on rsp_*.
// Throughput: one character per cycle unless the receiver stalls;
// the decode logic and quantum state update fit in the single stage
// between the two registers.
// Reset clears the alphabet mode to standard and the quantum state, and
// empties both registers. When the receiver stalls, the output register
// holds its result, the input register takes one more character, and
// req_tready then drops until the output drains.
`include "assert_macros.svh"

module base64_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   // character input
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] text_char
   input  logic       req_tlast,    // last_char
   // decoded output
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] data_byte
   output logic [2:0] rsp_tuser,    // [0] byte_valid, [2:1] status
   output logic       rsp_tlast,    // message_end
   // mode register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data      // alphabet_mode
);

   logic       mode_ff;
   logic       mode_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;
   logic       out_valid_ff;
   logic       out_valid_in;

   b64_pkg::result_type out_ff;
   b64_pkg::result_type result;

   logic out_open;
   logic advance;
   logic req_fire;

   assign out_open   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_open;
   assign req_tready = !in_valid_ff || out_open;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   b64_decode_core u_decode_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .alphabet_mode (mode_ff),
      .text_char     (in_char_ff),
      .last_char     (in_last_ff),
      .result        (result)
   );

   // Next values of the control registers
   always_comb begin
      mode_in = csr_valid ? csr_data : mode_ff;
      priority if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      priority if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= b64_pkg::MODE_STANDARD;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the character and the decoded result
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.data_byte;
   assign rsp_tuser  = {out_ff.status, out_ff.byte_valid};
   assign rsp_tlast  = out_ff.message_end;

   `B64_ASSERT_NEXT(a_accept_loads, req_fire, in_valid_ff,
      "accepted character not held in the input register")
   `B64_ASSERT_NEXT(a_advance_fills, advance, out_valid_ff,
      "decoded character not held in the output register")

endmodule
